@@ hdl/difficulty_retarget_compact_top_macros.svh @@
// assertion macros used by the checker file
`ifndef DIFFICULTY_RETARGET_COMPACT_TOP_MACROS_SVH
`define DIFFICULTY_RETARGET_COMPACT_TOP_MACROS_SVH

// clocked assertion, disabled while reset is high
`define DRC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("drc check failed");

// clocked assertion that also holds during reset
`define DRC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("drc check failed");

`endif

@@ hdl/drc_pkg.sv @@
// shared types and constants of the compact difficulty retarget block
package drc_pkg;

   localparam int TARGET_BYTES_DEF = 32;
   localparam int MANT_W = 23;
   localparam int QUOT_W = 25;
   localparam int SPAN_W = 34;
   localparam int PROD_W = MANT_W + SPAN_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [MANT_W-1:0] MANT_MASK = 23'h7FFFFF;
   localparam logic [QUOT_W-1:0] NORM_HIGH = 25'h07FFFFF;
   localparam logic [QUOT_W-1:0] NORM_LOW = 25'h0008000;
   localparam logic [QUOT_W-1:0] NORM_LOW2 = 25'h0000080;

   localparam logic [31:0] TT_RESET = 32'd1209600;
   localparam logic [63:0] LIMIT_RESET = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] LIMIT3_RESET = 64'h0000_0000_FFFF_FFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NO_RETARGET = 3'd0,
      CSR_TARGET_TIMESPAN = 3'd1,
      CSR_LIMIT_WORD_0 = 3'd2,
      CSR_LIMIT_WORD_1 = 3'd3,
      CSR_LIMIT_WORD_2 = 3'd4,
      CSR_LIMIT_WORD_3 = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [MANT_W-1:0] mant;
      logic [SPAN_W-1:0] span;
      logic [7:0] expo;
      logic [31:0] prev;
      logic nr;
   } span_stage_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [QUOT_W-1:0] nq;
      logic [7:0] expo;
      logic [31:0] prev;
      logic nr;
   } div_stage_type;

   typedef struct packed {
      logic [31:0] nb;
      logic nr;
   } norm_stage_type;

endpackage

@@ hdl/drc_req_if.sv @@
// request channel of the retarget block
interface drc_req_if;
   logic valid;
   logic ready;
   logic [31:0] prev_compact;
   logic [31:0] last_time;
   logic [31:0] first_time;

   modport source (output valid, output prev_compact, output last_time,
                   output first_time, input ready);
   modport sink (input valid, input prev_compact, input last_time,
                 input first_time, output ready);
endinterface

@@ hdl/drc_rsp_if.sv @@
// response channel of the retarget block
interface drc_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] next_compact;
   logic hit_limit;

   modport source (output valid, output next_compact, output hit_limit, input ready);
   modport sink (input valid, input next_compact, input hit_limit, output ready);
endinterface

@@ hdl/difficulty_retarget_compact_top.sv @@
// compact difficulty retarget pipeline, top level
// One item enters per cycle while the pipeline is not held by back pressure
// from the response side. The divider is a restoring divider, which resolves
// one quotient bit per pipeline stage over 25 stages; span clamp, multiply,
// normalize, target expansion and the limit compare each take one more stage.
// Every stage holds its item until the next one frees up, so bubbles collapse
// under back pressure. The user must write configuration only while the
// pipeline is empty; the block itself does not enforce it. The compact form of
// the limit is registered in the cycle after a limit write.
module difficulty_retarget_compact_top
   import drc_pkg::*;
#(
   parameter int TARGET_BYTES = TARGET_BYTES_DEF
) (
   input logic clock,
   input logic reset,
   drc_req_if.sink req_if,
   drc_rsp_if.source rsp_if,
   input logic csr_we,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int LIMIT_W = 8 * TARGET_BYTES;
   localparam int MSB_W = (TARGET_BYTES > 1) ? $clog2(TARGET_BYTES) : 1;
   localparam int NS = QUOT_W + 5;
   localparam int S_NORM = QUOT_W + 2;
   localparam int S_EXP = QUOT_W + 3;
   localparam int S_OUT = QUOT_W + 4;
   localparam logic [7:0] TB8 = 8'(TARGET_BYTES);

   // configuration registers
   logic no_retarget_ff;
   logic [31:0] tt_ff;
   logic [63:0] lim0_ff, lim1_ff, lim2_ff, lim3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         no_retarget_ff <= 1'b0;
         tt_ff <= TT_RESET;
         lim0_ff <= LIMIT_RESET;
         lim1_ff <= LIMIT_RESET;
         lim2_ff <= LIMIT_RESET;
         lim3_ff <= LIMIT3_RESET;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_NO_RETARGET: no_retarget_ff <= csr_wdata[0];
            CSR_TARGET_TIMESPAN: tt_ff <= csr_wdata[31:0];
            CSR_LIMIT_WORD_0: lim0_ff <= csr_wdata;
            CSR_LIMIT_WORD_1: lim1_ff <= csr_wdata;
            CSR_LIMIT_WORD_2: lim2_ff <= csr_wdata;
            CSR_LIMIT_WORD_3: lim3_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [255:0] lim_all;
   logic [LIMIT_W-1:0] lim_v;
   assign lim_all = {lim3_ff, lim2_ff, lim1_ff, lim0_ff};
   assign lim_v = lim_all[LIMIT_W-1:0];

   // compact form of the limit
   logic [TARGET_BYTES-1:0] lim_nz;
   logic [MSB_W-1:0] lim_msb;
   logic [7:0] lim_size;
   logic [23:0] lim_word;
   logic [31:0] lcmp_in, lcmp_ff;

   always_comb begin
      for (int i = 0; i < TARGET_BYTES; i++) begin
         lim_nz[i] = |lim_v[8*i +: 8];
      end
      lim_msb = '0;
      for (int i = 0; i < TARGET_BYTES; i++) begin
         if (lim_nz[i]) lim_msb = MSB_W'(i);
      end
      lim_size = 8'(lim_msb) + 8'd1;
      if (lim_size <= 8'd3) begin
         lim_word = lim_v[23:0] << {(8'd3 - lim_size), 3'b000};
      end else begin
         lim_word = 24'(lim_v >> {(lim_size - 8'd3), 3'b000});
      end
      if (lim_word[23]) begin
         lim_word = lim_word >> 8;
         lim_size = lim_size + 8'd1;
      end
      lcmp_in = (|lim_nz) ? {lim_size, lim_word} : 32'd0;
   end

   always_ff @(posedge clock) begin
      lcmp_ff <= lcmp_in;
   end

   // stage handshake
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || rsp_if.ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign req_if.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= req_if.valid;
         for (int i = 1; i < NS; i++) begin
            if (en[i]) vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // span clamp
   span_stage_type span_in, span_ff;
   logic [32:0] diff;
   logic signed [34:0] diff_s, lo_s, hi_s, span_s;

   always_comb begin
      diff = {1'b0, req_if.last_time} - {1'b0, req_if.first_time};
      diff_s = signed'({{2{diff[32]}}, diff});
      lo_s = signed'({5'b0, tt_ff[31:2]});
      hi_s = signed'({1'b0, tt_ff, 2'b00});
      span_s = diff_s;
      if (span_s < lo_s) span_s = lo_s;
      if (span_s > hi_s) span_s = hi_s;
      span_in.mant = req_if.prev_compact[22:0] & MANT_MASK;
      span_in.span = span_s[SPAN_W-1:0];
      span_in.expo = req_if.prev_compact[31:24];
      span_in.prev = req_if.prev_compact;
      span_in.nr = no_retarget_ff;
   end

   always_ff @(posedge clock) begin
      if (en[0]) span_ff <= span_in;
   end

   // product and divider stages
   div_stage_type div_ff [QUOT_W+1];
   div_stage_type div_in [QUOT_W+1];
   logic [PROD_W-1:0] prod;

   always_comb begin
      prod = PROD_W'(span_ff.mant) * PROD_W'(span_ff.span);
      div_in[0].rem = prod[PROD_W-1:QUOT_W];
      div_in[0].nq = prod[QUOT_W-1:0];
      div_in[0].expo = span_ff.expo;
      div_in[0].prev = span_ff.prev;
      div_in[0].nr = span_ff.nr;
   end

   for (genvar k = 0; k < QUOT_W; k++) begin : g_div
      logic [32:0] trial;
      logic ge;
      always_comb begin
         trial = {div_ff[k].rem, div_ff[k].nq[QUOT_W-1]};
         ge = trial >= {1'b0, tt_ff};
         div_in[k+1].rem = ge ? 32'(trial - {1'b0, tt_ff}) : trial[31:0];
         div_in[k+1].nq = {div_ff[k].nq[QUOT_W-2:0], ge};
         div_in[k+1].expo = div_ff[k].expo;
         div_in[k+1].prev = div_ff[k].prev;
         div_in[k+1].nr = div_ff[k].nr;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= QUOT_W; k++) begin
         if (en[k+1]) div_ff[k] <= div_in[k];
      end
   end

   // normalize
   norm_stage_type norm_in, norm_ff;
   logic [QUOT_W-1:0] q, m1, m2;
   logic [8:0] e1, e2, room;
   logic [1:0] want, sh;
   logic [7:0] e3;

   always_comb begin
      q = (tt_ff == 32'd0) ? '0 : div_ff[QUOT_W].nq;
      if (q > NORM_HIGH) begin
         m1 = q >> 8;
         e1 = {1'b0, div_ff[QUOT_W].expo} + 9'd1;
      end else begin
         m1 = q;
         e1 = {1'b0, div_ff[QUOT_W].expo};
      end
      if (m1 == '0) want = 2'd0;
      else if (m1 < NORM_LOW2) want = 2'd2;
      else if (m1 < NORM_LOW) want = 2'd1;
      else want = 2'd0;
      room = (e1 > 9'd1) ? (e1 - 9'd1) : 9'd0;
      sh = (9'(want) > room) ? room[1:0] : want;
      m2 = m1 << {sh, 3'b000};
      e2 = e1 - 9'(sh);
      // a zero mantissa walks the exponent all the way down
      if (m1 == '0) e2 = 9'd1;
      if (e2 > 9'(TB8)) e3 = TB8;
      else if (e2 < 9'd1) e3 = 8'd1;
      else e3 = e2[7:0];
      norm_in.nb = div_ff[QUOT_W].nr ? div_ff[QUOT_W].prev
                                     : {e3, 1'b0, m2[MANT_W-1:0]};
      norm_in.nr = div_ff[QUOT_W].nr;
   end

   always_ff @(posedge clock) begin
      if (en[S_NORM]) norm_ff <= norm_in;
   end

   // expand to full target
   logic [LIMIT_W-1:0] tgt_in, tgt_ff;
   norm_stage_type exp_ff;
   logic [7:0] sz;

   always_comb begin
      sz = norm_ff.nb[31:24];
      if (sz <= 8'd3) begin
         tgt_in = LIMIT_W'(norm_ff.nb[22:0]) >> {(8'd3 - sz), 3'b000};
      end else begin
         tgt_in = LIMIT_W'(norm_ff.nb[22:0]) << {(sz - 8'd3), 3'b000};
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_EXP]) begin
         tgt_ff <= tgt_in;
         exp_ff <= norm_ff;
      end
   end

   // limit compare and output register
   logic over;
   logic [31:0] next_in, next_ff;
   logic hit_in, hit_ff;

   always_comb begin
      over = !exp_ff.nr && (tgt_ff > lim_v);
      next_in = over ? lcmp_ff : exp_ff.nb;
      hit_in = over;
   end

   always_ff @(posedge clock) begin
      if (en[S_OUT]) begin
         next_ff <= next_in;
         hit_ff <= hit_in;
      end
   end

   assign rsp_if.valid = vld_ff[S_OUT];
   assign rsp_if.next_compact = next_ff;
   assign rsp_if.hit_limit = hit_ff;

endmodule

@@ hdl/drc_checker.sv @@
// port-level checks of the retarget block and their binding
`include "difficulty_retarget_compact_top_macros.svh"

module drc_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [31:0] next_compact,
   input logic hit_limit
);

   `DRC_ASSERT_ALWAYS(a_idle_after_reset, clock, $past(reset) |-> !rsp_valid)
   `DRC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(next_compact) && $stable(hit_limit))
   `DRC_ASSERT(a_limit_form, clock, reset, rsp_valid && hit_limit |-> !next_compact[23])

endmodule

bind difficulty_retarget_compact_top drc_checker u_drc_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .next_compact(rsp_if.next_compact),
   .hit_limit(rsp_if.hit_limit)
);
